### hw/rtl/byte_stuffed_frame_receiver_top_defines.svh
// assertion macros for the byte stuffed frame receiver
// no dependencies; included by the modules that carry assertions
`ifndef BYTE_STUFFED_FRAME_RECEIVER_TOP_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked out of reset only
`define BSFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bsfr assertion failed");
// checked at every edge, reset included
`define BSFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bsfr assertion failed");
`else
`define BSFR_ASSERT(lbl, prop)
`define BSFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### hw/rtl/bsfr_pkg.sv
// shared types and constants of the byte stuffed frame receiver
// no dependencies
package bsfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 64;
  localparam int unsigned CNT_W   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned FIELD_W = 2 * BYTE_W + BYTE_W + IDX_W + LEN_W + 2;
  localparam int unsigned TDATA_W = ((FIELD_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_START_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_END_CODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_ESCAPE_CODE = 3'd5;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_START_CODE      = 8'd2;
  localparam logic [BYTE_W-1:0] RST_END_CODE        = 8'd3;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE     = 8'd16;
  localparam logic [BYTE_W-1:0] RST_ESC_START_CODE  = 8'd18;
  localparam logic [BYTE_W-1:0] RST_ESC_END_CODE    = 8'd19;
  localparam logic [BYTE_W-1:0] RST_ESC_ESCAPE_CODE = 8'd26;

  // result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  frame_length;
    logic              checksum_ok;
    logic [BYTE_W-1:0] message_id;
    logic [BYTE_W-1:0] action_code;
    logic              overflow;
  } result_t;

endpackage

### hw/rtl/bsfr_in_stage.sv
// input register of the receiver: holds one raw byte until the decoder takes it
// depends on bsfr_pkg
module bsfr_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic [bsfr_pkg::BYTE_W-1:0] s_byte_i,
  output logic                      s_ready_o,
  input  logic                      advance_i,
  output logic                      valid_o,
  output logic [bsfr_pkg::BYTE_W-1:0] byte_o
);

  logic                        valid_q, valid_d;
  logic [bsfr_pkg::BYTE_W-1:0] byte_q;

  // refill in the same cycle the held word moves on
  assign s_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      byte_q <= s_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### hw/rtl/bsfr_decode.sv
// frame decoder: code registers, frame state, unescaping and checksum
// depends on bsfr_pkg and the assertion macro header
`include "byte_stuffed_frame_receiver_top_defines.svh"

module bsfr_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bsfr_pkg::BYTE_W-1:0]   cfg_wdata_i,
  input  logic                          advance_i,
  input  logic [bsfr_pkg::BYTE_W-1:0]   byte_i,
  output logic                          res_valid_o,
  output bsfr_pkg::result_t             res_o
);

  logic [bsfr_pkg::BYTE_W-1:0] start_q, end_q, esc_q;
  logic [bsfr_pkg::BYTE_W-1:0] esc_start_q, esc_end_q, esc_esc_q;

  logic                        in_frame_q, in_frame_d;
  logic                        pend_q, pend_d;
  logic [bsfr_pkg::CNT_W-1:0]  count_q, count_d;
  logic [bsfr_pkg::BYTE_W-1:0] xor_q, xor_d;
  logic [bsfr_pkg::BYTE_W-1:0] id_q, id_d;
  logic [bsfr_pkg::BYTE_W-1:0] action_q, action_d;
  logic                        drop_q, drop_d;

  logic [bsfr_pkg::BYTE_W-1:0] t1, t2, unesc;
  logic                        full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= bsfr_pkg::RST_START_CODE;
      end_q       <= bsfr_pkg::RST_END_CODE;
      esc_q       <= bsfr_pkg::RST_ESCAPE_CODE;
      esc_start_q <= bsfr_pkg::RST_ESC_START_CODE;
      esc_end_q   <= bsfr_pkg::RST_ESC_END_CODE;
      esc_esc_q   <= bsfr_pkg::RST_ESC_ESCAPE_CODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsfr_pkg::REG_START_CODE:      start_q     <= cfg_wdata_i;
        bsfr_pkg::REG_END_CODE:        end_q       <= cfg_wdata_i;
        bsfr_pkg::REG_ESCAPE_CODE:     esc_q       <= cfg_wdata_i;
        bsfr_pkg::REG_ESC_START_CODE:  esc_start_q <= cfg_wdata_i;
        bsfr_pkg::REG_ESC_END_CODE:    esc_end_q   <= cfg_wdata_i;
        bsfr_pkg::REG_ESC_ESCAPE_CODE: esc_esc_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // translations chain, a later rule may retranslate an earlier result
  always_comb begin
    t1    = (byte_i == esc_start_q) ? start_q : byte_i;
    t2    = (t1 == esc_end_q) ? end_q : t1;
    unesc = (t2 == esc_esc_q) ? esc_q : t2;
  end

  assign full = (count_q >= bsfr_pkg::CNT_W'(bsfr_pkg::MAX_FRAME_BYTES));

  always_comb begin
    in_frame_d  = in_frame_q;
    pend_d      = pend_q;
    count_d     = count_q;
    xor_d       = xor_q;
    id_d        = id_q;
    action_d    = action_q;
    drop_d      = drop_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (byte_i == start_q) begin
      in_frame_d = 1'b1;
      pend_d     = 1'b0;
      count_d    = '0;
      xor_d      = '0;
      id_d       = '0;
      action_d   = '0;
      drop_d     = 1'b0;
    end else if (in_frame_q) begin
      if (byte_i == end_q) begin
        in_frame_d         = 1'b0;
        pend_d             = 1'b0;
        res_valid_o        = 1'b1;
        res_o.kind         = bsfr_pkg::KIND_END;
        res_o.frame_length = bsfr_pkg::LEN_W'(count_q);
        res_o.checksum_ok  = (count_q != '0) && (xor_q == '0);
        res_o.message_id   = id_q;
        res_o.action_code  = action_q;
        res_o.overflow     = drop_q;
      end else if (byte_i == esc_q) begin
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
        if (full) begin
          drop_d = 1'b1;
        end else begin
          res_valid_o      = 1'b1;
          res_o.kind       = bsfr_pkg::KIND_BYTE;
          res_o.data_byte  = pend_q ? unesc : byte_i;
          res_o.byte_index = bsfr_pkg::IDX_W'(count_q);
          xor_d            = xor_q ^ res_o.data_byte;
          count_d          = count_q + 1'b1;
          if (count_q == bsfr_pkg::CNT_W'(1)) begin
            id_d = res_o.data_byte;
          end
          if (count_q == bsfr_pkg::CNT_W'(2)) begin
            action_d = res_o.data_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pend_q     <= 1'b0;
      count_q    <= '0;
      xor_q      <= '0;
      id_q       <= '0;
      action_q   <= '0;
      drop_q     <= 1'b0;
    end else if (advance_i) begin
      in_frame_q <= in_frame_d;
      pend_q     <= pend_d;
      count_q    <= count_d;
      xor_q      <= xor_d;
      id_q       <= id_d;
      action_q   <= action_d;
      drop_q     <= drop_d;
    end
  end

  `BSFR_ASSERT(a_count_bounded,
    count_q <= bsfr_pkg::CNT_W'(bsfr_pkg::MAX_FRAME_BYTES))
  `BSFR_ASSERT(a_pend_in_frame, pend_q |-> in_frame_q)
  `BSFR_ASSERT(a_end_closes,
    advance_i && res_valid_o && res_o.kind |=> !in_frame_q && !pend_q)
  `BSFR_ASSERT(a_drop_when_full, drop_q && in_frame_q |-> full)

endmodule

### hw/rtl/bsfr_out_stage.sv
// result register of the receiver: packs a result and holds it for the consumer
// depends on bsfr_pkg
module bsfr_out_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         advance_i,
  input  bsfr_pkg::result_t            res_i,
  output logic                         can_take_o,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [bsfr_pkg::TDATA_W-1:0] m_data_o,
  output logic                         m_user_o
);

  logic                         valid_q, valid_d;
  logic [bsfr_pkg::TDATA_W-1:0] data_q;
  logic                         user_q;

  assign can_take_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q && !m_ready_i;
    if (advance_i) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && load_i) begin
      data_q <= bsfr_pkg::TDATA_W'({res_i.overflow, res_i.action_code, res_i.message_id,
                                    res_i.checksum_ok, res_i.frame_length,
                                    res_i.byte_index, res_i.data_byte});
      user_q <= res_i.kind;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_user_o  = user_q;

endmodule

### hw/rtl/byte_stuffed_frame_receiver_top.sv
// top level of the byte stuffed frame receiver
// depends on bsfr_pkg, bsfr_in_stage, bsfr_decode and bsfr_out_stage
//
// Takes one raw line byte per word on the slave stream and emits zero or one
// result per byte: a stored payload byte with its index, or a frame end report
// with length, id byte, action byte, checksum status and overflow flag. The
// block accepts a byte every cycle; each byte is decoded straight out of the
// input register into the result register. Throughput drops only while the
// master side stalls. The code registers must be written while the stream is
// idle.
module byte_stuffed_frame_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bsfr_pkg::BYTE_W-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // data_byte, byte_index, frame_length, checksum_ok, message_id, action_code,
  // overflow, one zero pad bit
  output logic [bsfr_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser   // kind
);

  logic                        in_valid;
  logic [bsfr_pkg::BYTE_W-1:0] in_byte;
  logic                        advance;
  logic                        can_take;
  logic                        res_valid;
  bsfr_pkg::result_t           res;

  assign advance = in_valid && can_take;

  bsfr_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_byte_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  bsfr_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bsfr_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .advance_i  (advance),
    .res_i      (res),
    .can_take_o (can_take),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser)
  );

endmodule
